### rtl/core/srs_pkg.sv
package srs_pkg;

	localparam int MAX_DISKS_DEF = 4;

	localparam int DISK_W = 2;
	localparam int BLK_W = 32;
	localparam int CNT_W = 16;
	localparam int OFF_W = 16;
	localparam int ST_W = 2;
	localparam int CNTEFF_W = 3;
	localparam int MASK_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 72;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE0 = 3'd2;

	typedef enum logic [1:0] {
		ACT_READ = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_ADMIN_READ = 2'd2,
		ACT_ADMIN_WRITE = 2'd3
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK = 2'd0,
		ST_MISSING = 2'd1,
		ST_RANGE = 2'd2,
		ST_NODISK = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EMIT_SPAN,
		EMIT_RANGE,
		EMIT_ADMIN_WRITE,
		EMIT_ADMIN_READ,
		EMIT_NODISK
	} emit_kind_t;

	typedef struct packed {
		logic load_req;
		logic sum_step;
		logic walk_step;
		logic adm_step;
		logic emit;
		emit_kind_t kind;
	} srs_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic range_err;
		logic span_skip;
		logic span_final;
		logic adm_hit;
		logic adm_final;
		logic no_present;
		logic out_free;
	} srs_status_t;

endpackage

### rtl/core/srs_ctrl.sv
module srs_ctrl
	import srs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  action_t     in_action,
	output logic        in_ready,
	input  srs_status_t st,
	output srs_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_CHECK,
		S_WALK,
		S_ADMW,
		S_ADMR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		cmd = '0;
		cmd.kind = EMIT_SPAN;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					unique case (in_action)
						ACT_READ, ACT_WRITE: state_d = S_SUM;
						ACT_ADMIN_WRITE: state_d = S_ADMW;
						ACT_ADMIN_READ: state_d = S_ADMR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (st.idx_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.range_err) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = EMIT_RANGE;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (st.span_skip) begin
					cmd.walk_step = 1'b1;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EMIT_SPAN;
					if (st.span_final) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_step = 1'b1;
					end
				end
			end
			S_ADMW: begin
				priority if (st.no_present) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.kind = EMIT_NODISK;
						state_d = S_IDLE;
					end
				end else if (!st.adm_hit) begin
					cmd.adm_step = 1'b1;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EMIT_ADMIN_WRITE;
					if (st.adm_final) begin
						state_d = S_IDLE;
					end else begin
						cmd.adm_step = 1'b1;
					end
				end
			end
			S_ADMR: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = st.no_present ? EMIT_NODISK : EMIT_ADMIN_READ;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule

### rtl/core/srs_dp.sv
module srs_dp
	import srs_pkg::*;
#(
	parameter int MAX_DISKS = MAX_DISKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BLK_W-1:0]      in_first,
	input  logic [CNT_W-1:0]      in_count,
	input  logic [OFF_W-1:0]      in_boff,
	input  srs_cmd_t              cmd,
	output srs_status_t           st,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DISK_W-1:0]     out_disk,
	output logic [BLK_W-1:0]      out_block,
	output logic [OFF_W-1:0]      out_boff,
	output logic [CNT_W-1:0]      out_count,
	output status_t               out_status,
	output logic                  out_last
);

	localparam int SEL_W = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
	localparam int ACC_W = BLK_W + 2;

	// next present disk after p, stepping upward and wrapping past count - 1
	function automatic logic [DISK_W-1:0] next_present(
		input logic [DISK_W-1:0]   p,
		input logic [MASK_W-1:0]   pv,
		input logic [CNTEFF_W-1:0] c
	);
		logic [CNTEFF_W-1:0] n;
		logic [DISK_W-1:0]   res;
		logic                found;
		n = {1'b0, p};
		res = '0;
		found = 1'b0;
		for (int t = 0; t < MASK_W; t++) begin
			if (CNTEFF_W'(t) < c && !found) begin
				n = (n + 1'b1 >= c) ? '0 : n + 1'b1;
				if (pv[n[DISK_W-1:0]]) begin
					found = 1'b1;
					res = n[DISK_W-1:0];
				end
			end
		end
		return res;
	endfunction

	logic [CNTEFF_W-1:0] dcount_q;
	logic [MASK_W-1:0]   mask_q;
	logic [BLK_W-1:0]    size_q [MAX_DISKS];

	logic [BLK_W-1:0]  first_q;
	logic [CNT_W-1:0]  count_q;
	logic [OFF_W-1:0]  boff_q;
	logic [BLK_W:0]    last1_q;
	logic [ACC_W-1:0]  total_q;
	logic [ACC_W-1:0]  start_q;
	logic [ACC_W-1:0]  end_q;
	logic [DISK_W-1:0] idx_q;
	logic [DISK_W-1:0] rp_q;
	logic              started_q;

	logic              out_valid_q;
	logic [DISK_W-1:0] out_disk_q;
	logic [BLK_W-1:0]  out_block_q;
	logic [OFF_W-1:0]  out_boff_q;
	logic [CNT_W-1:0]  out_count_q;
	status_t           out_status_q;
	logic              out_last_q;

	logic [CNTEFF_W-1:0] c_eff;
	logic [MASK_W-1:0]   pv;
	logic [CNTEFF_W-1:0] idx_inc;
	logic [CNTEFF_W-1:0] cfg_slot;
	logic [BLK_W-1:0]    size_cur;
	logic [BLK_W-1:0]    size_nxt;
	logic [ACC_W-1:0]    first_x;
	logic [ACC_W-1:0]    last1_x;
	logic [ACC_W-1:0]    span_lo;
	logic [ACC_W-1:0]    span_hi;
	logic [ACC_W-1:0]    span_blk;
	logic [ACC_W-1:0]    span_off;
	logic [ACC_W-1:0]    span_cnt;
	logic                adm_final;
	logic [DISK_W-1:0]   rp_eff;
	logic [DISK_W-1:0]   rp_nxt;

	always_comb begin
		if (dcount_q == '0) begin
			c_eff = CNTEFF_W'(1);
		end else if (dcount_q > CNTEFF_W'(MAX_DISKS)) begin
			c_eff = CNTEFF_W'(MAX_DISKS);
		end else begin
			c_eff = dcount_q;
		end
	end

	always_comb begin
		for (int j = 0; j < MASK_W; j++) begin
			pv[j] = mask_q[j] && (CNTEFF_W'(j) < c_eff);
		end
	end

	assign idx_inc = {1'b0, idx_q} + 1'b1;
	assign cfg_slot = cfg_index - REG_DISK_SIZE0;
	assign size_cur = size_q[idx_q[SEL_W-1:0]];
	assign size_nxt = (idx_inc < CNTEFF_W'(MAX_DISKS)) ? size_q[idx_inc[SEL_W-1:0]] : '0;

	// overlap of the request with the disk held in start_q .. end_q
	assign first_x = {2'b00, first_q};
	assign last1_x = {1'b0, last1_q};
	assign span_lo = (first_x < start_q) ? start_q : first_x;
	assign span_hi = (last1_x < end_q) ? last1_x : end_q;
	assign span_blk = span_lo - start_q;
	assign span_off = span_lo - first_x;
	assign span_cnt = span_hi - span_lo;

	always_comb begin
		adm_final = 1'b1;
		for (int j = 0; j < MASK_W; j++) begin
			if (DISK_W'(j) > idx_q && pv[j]) begin
				adm_final = 1'b0;
			end
		end
	end

	assign rp_eff = started_q ? rp_q : next_present(rp_q, pv, c_eff);
	assign rp_nxt = next_present(rp_eff, pv, c_eff);

	always_comb begin
		st.idx_last = ({1'b0, idx_q} == c_eff - 1'b1);
		st.range_err = (count_q == '0) || (last1_x > total_q);
		st.span_skip = (first_x >= end_q);
		st.span_final = (last1_x <= end_q);
		st.adm_hit = pv[idx_q];
		st.adm_final = adm_final;
		st.no_present = (pv == '0);
		st.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q <= CNTEFF_W'(1);
			mask_q <= '1;
			for (int j = 0; j < MAX_DISKS; j++) begin
				size_q[j] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_DISK_COUNT) begin
				dcount_q <= cfg_data[CNTEFF_W-1:0];
			end else if (cfg_index == REG_PRESENT_MASK) begin
				mask_q <= cfg_data[MASK_W-1:0];
			end else if (cfg_index >= REG_DISK_SIZE0 && cfg_slot < CNTEFF_W'(MAX_DISKS)) begin
				size_q[cfg_slot[SEL_W-1:0]] <= cfg_data[BLK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			first_q <= in_first;
			count_q <= in_count;
			boff_q <= in_boff;
			last1_q <= {1'b0, in_first} + {{(BLK_W-CNT_W+1){1'b0}}, in_count};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			total_q <= '0;
			start_q <= '0;
			end_q <= '0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
				total_q <= '0;
			end else if (cmd.sum_step) begin
				total_q <= total_q + {2'b00, size_cur};
				if (st.idx_last) begin
					idx_q <= '0;
					start_q <= '0;
					end_q <= {2'b00, size_q[0]};
				end else begin
					idx_q <= idx_inc[DISK_W-1:0];
				end
			end else if (cmd.walk_step || cmd.adm_step) begin
				idx_q <= idx_inc[DISK_W-1:0];
				start_q <= end_q;
				end_q <= end_q + {2'b00, size_nxt};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			started_q <= 1'b0;
		end else if (cmd.emit && cmd.kind == EMIT_ADMIN_READ) begin
			rp_q <= rp_nxt;
			started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.kind)
				EMIT_SPAN: begin
					out_disk_q <= idx_q;
					out_block_q <= span_blk[BLK_W-1:0];
					out_boff_q <= span_off[OFF_W-1:0];
					out_count_q <= span_cnt[CNT_W-1:0];
					out_status_q <= pv[idx_q] ? ST_OK : ST_MISSING;
					out_last_q <= st.span_final;
				end
				EMIT_ADMIN_WRITE: begin
					out_disk_q <= idx_q;
					out_block_q <= first_q + 1'b1;
					out_boff_q <= boff_q;
					out_count_q <= count_q;
					out_status_q <= ST_OK;
					out_last_q <= adm_final;
				end
				EMIT_ADMIN_READ: begin
					out_disk_q <= rp_eff;
					out_block_q <= first_q + 1'b1;
					out_boff_q <= boff_q;
					out_count_q <= count_q;
					out_status_q <= pv[rp_eff] ? ST_OK : ST_MISSING;
					out_last_q <= 1'b1;
				end
				EMIT_RANGE, EMIT_NODISK: begin
					out_disk_q <= '0;
					out_block_q <= '0;
					out_boff_q <= '0;
					out_count_q <= '0;
					out_status_q <= (cmd.kind == EMIT_RANGE) ? ST_RANGE : ST_NODISK;
					out_last_q <= 1'b1;
				end
				default: begin
					out_disk_q <= '0;
					out_block_q <= '0;
					out_boff_q <= '0;
					out_count_q <= '0;
					out_status_q <= ST_NODISK;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_disk = out_disk_q;
	assign out_block = out_block_q;
	assign out_boff = out_boff_q;
	assign out_count = out_count_q;
	assign out_status = out_status_q;
	assign out_last = out_last_q;

endmodule

### rtl/core/span_request_splitter.sv
// sequence: a read or write is accepted, the disk sizes are summed serially on one adder, the range
// is checked, then the member disks are walked in order, one disk per cycle unless the output stalls
// throughput: one request at a time, limited by the serial size sum and the disk walk; a new request
// is accepted only after the previous one has issued its last sub-request
// reset: arst_n asynchronous active low; clears the output, the round robin pointer and restores
// disk_count 1, present_mask all ones and all disk sizes zero
module span_request_splitter
	import srs_pkg::*;
#(
	parameter int MAX_DISKS = MAX_DISKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_block[31:0], block_count[47:32], buffer_offset_in[63:48]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// disk_index[1:0], disk_block[33:2], buffer_offset[49:34], sub_count[65:50], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [ST_W-1:0]       m_tuser,
	output logic                  m_tlast
);

	srs_cmd_t          cmd;
	srs_status_t       st;
	logic [DISK_W-1:0] out_disk;
	logic [BLK_W-1:0]  out_block;
	logic [OFF_W-1:0]  out_boff;
	logic [CNT_W-1:0]  out_count;
	status_t           out_status;

	srs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (action_t'(s_tuser)),
		.in_ready  (s_tready),
		.st        (st),
		.cmd       (cmd)
	);

	srs_dp #(
		.MAX_DISKS (MAX_DISKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_first   (s_tdata[31:0]),
		.in_count   (s_tdata[47:32]),
		.in_boff    (s_tdata[63:48]),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_disk   (out_disk),
		.out_block  (out_block),
		.out_boff   (out_boff),
		.out_count  (out_count),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'b0, out_count, out_boff, out_block, out_disk};
	assign m_tuser = out_status;

endmodule

### rtl/core/srs_checker.sv
module srs_checker
	import srs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [ST_W-1:0]       m_tuser,
	input logic                  m_tlast
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// range and no-disk results stand alone with zero payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_NODISK) |-> m_tlast && m_tdata == '0)
		else $error("error result not alone or not zero");

	// one request at a time: busy right after a transaction is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accepted transaction");

	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind span_request_splitter srs_checker u_srs_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps

module tb;
	import srs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

	typedef struct {
		action_t     act;
		logic [31:0] first;
		logic [15:0] cnt;
		logic [15:0] boff;
	} disk_req_t;

	typedef struct packed {
		logic [1:0]  disk;
		logic [31:0] blk;
		logic [15:0] off;
		logic [15:0] cnt;
		status_t     st;
		logic        fin;
	} sub_req_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [ST_W-1:0]       m_tuser;
	logic                  m_tlast;

	// mirror of the block's registers and round robin state
	logic [2:0]  mdl_disk_count = 3'd1;
	logic [3:0]  mdl_mask = 4'hF;
	logic [31:0] mdl_size [4] = '{default: '0};
	logic [1:0]  mdl_rr_ptr = '0;
	logic        mdl_rr_started = 1'b0;

	disk_req_t pending_reqs [$];
	sub_req_t  expected_subs [$];
	disk_req_t nxt_req;
	sub_req_t  exp_sub;

	int reqs_queued = 0;
	int reqs_taken = 0;
	int subs_checked = 0;
	int err_count = 0;
	int phases_done = 0;
	int status_seen [4] = '{default: 0};
	int gap_left = 0;
	int stall_left = 0;
	bit squeeze_done = 0;
	bit squeeze_armed = 0;
	bit burst = 0;
	bit steady = 0;

	span_request_splitter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int eff_disks();
		int c;
		c = mdl_disk_count;
		if (c == 0) c = 1;
		if (c > MAX_DISKS_DEF) c = MAX_DISKS_DEF;
		return c;
	endfunction

	function automatic bit is_present(int i);
		return i < eff_disks() && mdl_mask[i & 3];
	endfunction

	// next present disk after p, -1 when there is none
	function automatic int next_present(int p);
		int c;
		int n;
		c = eff_disks();
		n = p;
		for (int t = 0; t < c; t++) begin
			n = (n + 1 >= c) ? 0 : n + 1;
			if (is_present(n)) return n;
		end
		return -1;
	endfunction

	function automatic sub_req_t mk_sub(int disk, logic [31:0] blk, logic [15:0] off,
			logic [15:0] cnt, status_t st);
		sub_req_t s;
		s.disk = 2'(disk);
		s.blk = blk;
		s.off = off;
		s.cnt = cnt;
		s.st = st;
		s.fin = 1'b0;
		return s;
	endfunction

	// works out the sub-requests one request causes and queues them
	function automatic void split_request(action_t act, logic [31:0] first,
			logic [15:0] cnt_in, logic [15:0] boff);
		sub_req_t    subs [4];
		int          n;
		int          c;
		int          nx;
		logic [63:0] total, f, last_blk, start, seg_end, blk, off, cnt;
		n = 0;
		c = eff_disks();
		case (act)
			ACT_READ, ACT_WRITE: begin
				total = '0;
				for (int i = 0; i < c; i++) total += mdl_size[i];
				f = first;
				last_blk = f + cnt_in - 1;
				if (cnt_in == 0 || last_blk >= total) begin
					subs[0] = mk_sub(0, '0, '0, '0, ST_RANGE);
					n = 1;
				end else begin
					start = '0;
					for (int i = 0; i < c; i++) begin
						seg_end = start + mdl_size[i];
						if (f < seg_end && last_blk >= start) begin
							if (f < start) begin
								blk = '0;
								off = start - f;
							end else begin
								blk = f - start;
								off = '0;
							end
							if (last_blk >= seg_end) cnt = mdl_size[i] - blk;
							else if (f < start) cnt = last_blk - start + 1;
							else cnt = last_blk - f + 1;
							subs[n] = mk_sub(i, blk[31:0], off[15:0], cnt[15:0],
								is_present(i) ? ST_OK : ST_MISSING);
							n++;
						end
						start = seg_end;
					end
				end
			end
			ACT_ADMIN_WRITE: begin
				for (int i = 0; i < c; i++) begin
					if (is_present(i)) begin
						subs[n] = mk_sub(i, first + 32'd1, boff, cnt_in, ST_OK);
						n++;
					end
				end
				if (n == 0) begin
					subs[0] = mk_sub(0, '0, '0, '0, ST_NODISK);
					n = 1;
				end
			end
			default: begin
				if (next_present(mdl_rr_ptr) < 0) begin
					subs[0] = mk_sub(0, '0, '0, '0, ST_NODISK);
					n = 1;
				end else begin
					// pointer is moved once before the very first admin read
					if (!mdl_rr_started) begin
						mdl_rr_ptr = 2'(next_present(mdl_rr_ptr));
						mdl_rr_started = 1'b1;
					end
					subs[0] = mk_sub(mdl_rr_ptr, first + 32'd1, boff, cnt_in,
						is_present(mdl_rr_ptr) ? ST_OK : ST_MISSING);
					n = 1;
					nx = next_present(mdl_rr_ptr);
					if (nx >= 0) mdl_rr_ptr = 2'(nx);
				end
			end
		endcase
		for (int k = 0; k < n; k++) begin
			if (k == n - 1) subs[k].fin = 1'b1;
			expected_subs.push_back(subs[k]);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 92) return $urandom_range(1, 3);
		else return $urandom_range(8, 40);
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				split_request(action_t'(s_tuser), s_tdata[31:0], s_tdata[47:32],
					s_tdata[63:48]);
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					nxt_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {nxt_req.boff, nxt_req.cnt, nxt_req.first};
					s_tuser <= nxt_req.act;
					gap_left = (burst || steady) ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sub-request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			squeeze_done = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_subs.size() == 0) begin
					$display("%0t: unexpected sub-request disk %0d status %0d", $time,
						m_tdata[1:0], m_tuser);
					err_count++;
				end else begin
					exp_sub = expected_subs.pop_front();
					if ({m_tdata, m_tuser, m_tlast} !== {6'b0, exp_sub.cnt, exp_sub.off,
							exp_sub.blk, exp_sub.disk, exp_sub.st, exp_sub.fin}) begin
						$display("%0t: mismatch, expected disk %0d block %h offset %h count %h",
							$time, exp_sub.disk, exp_sub.blk, exp_sub.off, exp_sub.cnt,
							" status %0d last %0b fill 0", exp_sub.st, exp_sub.fin);
						$display("%0t:           got disk %0d block %h offset %h count %h",
							$time, m_tdata[1:0], m_tdata[33:2], m_tdata[49:34],
							m_tdata[65:50], " status %0d last %0b fill %h", m_tuser,
							m_tlast, m_tdata[71:66]);
						err_count++;
					end
				end
				subs_checked++;
				status_seen[m_tuser]++;
			end
			// one long hold-off so the block backs up into its input
			if (squeeze_armed && !squeeze_done) begin
				squeeze_done = 1;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!steady) stall_left = pick_gap();
			end
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DISK_COUNT) mdl_disk_count = data[2:0];
		else if (idx == REG_PRESENT_MASK) mdl_mask = data[3:0];
		else if (idx >= REG_DISK_SIZE0 && idx < REG_SPARE) mdl_size[idx - REG_DISK_SIZE0] = data;
	endtask

	task automatic queue_req(action_t act, logic [31:0] first, logic [15:0] cnt,
			logic [15:0] boff);
		pending_reqs.push_back('{act, first, cnt, boff});
		reqs_queued++;
	endtask

	task automatic wait_drained();
		while (reqs_taken != reqs_queued || expected_subs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		phases_done++;
	endtask

	// mostly requests aimed at disk boundaries, some pure noise
	task automatic queue_random_req();
		int          r;
		int          k;
		logic [63:0] cut_pt;
		logic [31:0] first;
		logic [15:0] cnt;
		action_t     act;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			queue_req(action_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
				16'($urandom));
		end else begin
			act = (r < 40) ? ACT_READ : (r < 65) ? ACT_WRITE :
				(r < 83) ? ACT_ADMIN_READ : ACT_ADMIN_WRITE;
			k = $urandom_range(0, eff_disks());
			cut_pt = '0;
			for (int i = 0; i < k; i++) cut_pt += mdl_size[i];
			first = cut_pt[31:0] + 32'($urandom_range(0, 24)) - 32'd12;
			if (act == ACT_ADMIN_READ || act == ACT_ADMIN_WRITE)
				first = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
			cnt = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(1, 40)) :
				16'($urandom_range(1, 65535));
			queue_req(act, first, cnt, 16'($urandom));
		end
	endtask

	task automatic random_phase(int n_items, bit big_sizes);
		cfg_write(REG_DISK_COUNT, $urandom_range(0, 7));
		cfg_write(REG_PRESENT_MASK, $urandom_range(0, 15));
		for (int i = 0; i < 4; i++) begin
			if (big_sizes)
				cfg_write(REG_DISK_SIZE0 + CFG_IDX_W'(i),
					($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
			else
				cfg_write(REG_DISK_SIZE0 + CFG_IDX_W'(i), $urandom_range(0, 40));
		end
		if ($urandom_range(0, 1)) cfg_write(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), $urandom);
		repeat (n_items) queue_random_req();
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one disk of zero size
		queue_req(ACT_READ, 32'd0, 16'd1, 16'd0);
		queue_req(ACT_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		queue_req(ACT_ADMIN_READ, 32'd5, 16'd3, 16'd7);
		queue_req(ACT_ADMIN_WRITE, 32'hFFFF_FFFF, 16'd1, 16'hFFFF);
		wait_drained();

		// four small disks, disk one empty, disk two absent
		cfg_write(REG_DISK_COUNT, 32'd4);
		cfg_write(REG_PRESENT_MASK, 32'hB);
		cfg_write(REG_DISK_SIZE0, 32'd10);
		cfg_write(REG_DISK_SIZE0 + 3'd1, 32'd0);
		cfg_write(REG_DISK_SIZE0 + 3'd2, 32'd7);
		cfg_write(REG_DISK_SIZE0 + 3'd3, 32'd20);
		queue_req(ACT_READ, 32'd0, 16'd10, 16'd0);
		queue_req(ACT_READ, 32'd0, 16'd37, 16'd0);
		queue_req(ACT_WRITE, 32'd9, 16'd2, 16'd0);
		queue_req(ACT_READ, 32'd36, 16'd1, 16'd0);
		queue_req(ACT_READ, 32'd36, 16'd2, 16'd0);
		queue_req(ACT_WRITE, 32'd5, 16'd0, 16'd0);
		queue_req(ACT_READ, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
		queue_req(ACT_ADMIN_WRITE, 32'd100, 16'd8, 16'd3);
		repeat (3) queue_req(ACT_ADMIN_READ, 32'd200, 16'd4, 16'd9);
		wait_drained();

		// drop the disk the round robin points at
		cfg_write(REG_PRESENT_MASK, 32'(4'hF & ~(4'b0001 << mdl_rr_ptr)));
		repeat (2) queue_req(ACT_ADMIN_READ, 32'd1, 16'd1, 16'd1);
		wait_drained();

		// full size disks, count above the maximum, spare indexes
		cfg_write(REG_DISK_COUNT, 32'd7);
		cfg_write(REG_PRESENT_MASK, 32'hF);
		for (int i = 0; i < 4; i++) cfg_write(REG_DISK_SIZE0 + CFG_IDX_W'(i), 32'hFFFF_FFFF);
		cfg_write(REG_SPARE, 32'hFFFF_FFFF);
		cfg_write(REG_SPARE + 3'd1, 32'h0000_0001);
		queue_req(ACT_READ, 32'hFFFF_FFF0, 16'hFFFF, 16'h1234);
		queue_req(ACT_WRITE, 32'hFFFF_FFFF, 16'd1, 16'd0);
		queue_req(ACT_ADMIN_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		wait_drained();

		// no disk present, count zero acts as one
		cfg_write(REG_PRESENT_MASK, 32'd0);
		cfg_write(REG_DISK_COUNT, 32'd0);
		queue_req(ACT_ADMIN_READ, 32'd3, 16'd2, 16'd1);
		queue_req(ACT_ADMIN_WRITE, 32'd3, 16'd2, 16'd1);
		queue_req(ACT_READ, 32'd0, 16'd5, 16'd0);
		wait_drained();

		// mask bits above the count are ignored
		cfg_write(REG_PRESENT_MASK, 32'hE);
		queue_req(ACT_ADMIN_READ, 32'd0, 16'd1, 16'd0);
		queue_req(ACT_ADMIN_WRITE, 32'd0, 16'd1, 16'd0);
		wait_drained();

		random_phase(62, 0);
		random_phase(62, 1);
		steady = 1;
		random_phase(62, 0);
		steady = 0;
		random_phase(62, 0);
		random_phase(62, 1);
		random_phase(62, 0);
		burst = 1;
		squeeze_armed = 1;
		random_phase(30, 0);
		burst = 0;

		repeat (50) @(posedge clk);
		$display("Covered %0d requests and %0d sub-requests over %0d settings", reqs_taken,
			subs_checked, phases_done);
		$display("Status mix: ok %0d, missing %0d, out of range %0d, no disk %0d",
			status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_RANGE],
			status_seen[ST_NODISK]);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### span_request_splitter.f
rtl/core/srs_pkg.sv
rtl/core/srs_ctrl.sv
rtl/core/srs_dp.sv
rtl/core/span_request_splitter.sv
rtl/core/srs_checker.sv
test/tb.sv
